[rtl/sst_pkg.sv]
package sst_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_DUP     = 3'd1;
    localparam logic [2:0] STAT_MISSING = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_RANGE   = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [5:0]  index;
    } sst_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data;
        logic [6:0]  count;
    } sst_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PLACE,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_DONE
    } sst_state_t;

endpackage

[rtl/sorted_set_table.sv]
// Sorted set table: up to CAPACITY distinct keys held in ascending order in a
// single-port memory. One operation (insert, delete, read at index) is taken
// at a time; s_ready is high only while the sequencer is idle, and a finished
// result may wait in the output register while the next operation runs.
// Every memory access uses the single port, so the steps of an operation run
// in turn: a read fetches the slot at the index; an insert runs at most 7
// binary-search probes, shifts up to 63 entries up one slot each and places the
// key; a delete runs the probes and shifts the entries above the found key down
// one slot each. Inserting into a full table answers full even for a stored key.
// Memory contents are undefined after reset; no value read past the count is used.
module sorted_set_table
    import sst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sst_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sst_out_t m_data
);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rdata_reg;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [KEY_WIDTH-1:0] mem_wdata;

    sst_state_t state_reg, state_next;
    logic [1:0]           func_reg, func_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [5:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [2:0]           res_status_reg, res_status_next;
    logic [KEY_WIDTH-1:0] res_data_reg, res_data_next;
    logic                 m_valid_reg, m_valid_next;
    sst_out_t             m_data_reg, m_data_next;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] ptr_inc;
    logic             out_free;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CNT_W:1];
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.func)
                        FN_INSERT: state_next = (count_reg >= CNT_W'(CAPACITY)) ?
                                                ST_DONE : ST_PROBE;
                        FN_DELETE: state_next = ST_PROBE;
                        FN_READ:   state_next = ({1'b0, s_data.index} >= count_reg) ?
                                                ST_DONE : ST_FETCH;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_PROBE: begin
                if (lo_reg < hi_reg) begin
                    state_next = ST_COMPARE;
                end else if (func_reg == FN_INSERT) begin
                    state_next = ST_MOVE_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_COMPARE: begin
                if (key_reg != rdata_reg) begin
                    state_next = ST_PROBE;
                end else if (func_reg == FN_INSERT) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MOVE_RD;
                end
            end
            ST_MOVE_RD: begin
                if (func_reg == FN_INSERT) begin
                    state_next = (ptr_reg > pos_reg) ? ST_MOVE_WR : ST_PLACE;
                end else begin
                    state_next = (ptr_inc < count_reg) ? ST_MOVE_WR : ST_DONE;
                end
            end
            ST_MOVE_WR:    state_next = ST_MOVE_RD;
            ST_PLACE:      state_next = ST_DONE;
            ST_FETCH:      state_next = ST_FETCH_WAIT;
            ST_FETCH_WAIT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        func_next       = func_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_addr        = ptr_reg[ADDR_W-1:0];
        mem_we          = 1'b0;
        mem_wdata       = rdata_reg;
        case (state_reg)
            ST_IDLE: begin
                func_next       = s_data.func;
                key_next        = s_data.key[KEY_WIDTH-1:0];
                idx_next        = s_data.index;
                lo_next         = '0;
                hi_next         = count_reg;
                res_data_next   = '0;
                res_status_next = STAT_OK;
                if (s_data.func == FN_INSERT && count_reg >= CNT_W'(CAPACITY)) begin
                    res_status_next = STAT_FULL;
                end
                if (s_data.func == FN_READ && {1'b0, s_data.index} >= count_reg) begin
                    res_status_next = STAT_RANGE;
                end
            end
            ST_PROBE: begin
                mid_next = mid_calc;
                mem_addr = mid_calc[ADDR_W-1:0];
                if (lo_reg >= hi_reg) begin
                    pos_next = lo_reg;
                    ptr_next = count_reg;
                    if (func_reg != FN_INSERT) begin
                        res_status_next = STAT_MISSING;
                    end
                end
            end
            ST_COMPARE: begin
                if (key_reg < rdata_reg) begin
                    hi_next = mid_reg;
                end else if (key_reg > rdata_reg) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else if (func_reg == FN_INSERT) begin
                    res_status_next = STAT_DUP;
                end else begin
                    res_data_next = rdata_reg;
                    ptr_next      = mid_reg;
                end
            end
            ST_MOVE_RD: begin
                if (func_reg == FN_INSERT) begin
                    mem_addr = ADDR_W'(ptr_reg - CNT_W'(1));
                end else begin
                    mem_addr = ptr_inc[ADDR_W-1:0];
                    if (ptr_inc >= count_reg) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            ST_MOVE_WR: begin
                mem_we   = 1'b1;
                ptr_next = (func_reg == FN_INSERT) ? ptr_reg - CNT_W'(1) : ptr_inc;
            end
            ST_PLACE: begin
                mem_addr   = pos_reg[ADDR_W-1:0];
                mem_we     = 1'b1;
                mem_wdata  = key_reg;
                count_next = count_reg + CNT_W'(1);
            end
            ST_FETCH: begin
                mem_addr = idx_reg[ADDR_W-1:0];
            end
            ST_FETCH_WAIT: begin
                res_data_next = rdata_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_data_next.status = res_status_reg;
                    m_data_next.data   = 32'(res_data_reg);
                    m_data_next.count  = 7'(count_reg);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg       <= func_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        m_data_reg     <= m_data_next;
    end

endmodule

[rtl/sst_checker.sv]
module sst_checker
    import sst_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input sst_out_t m_data
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.count <= 7'(CAPACITY))
        else $error("count past capacity");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= STAT_RANGE)
        else $error("unknown status");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |-> m_data.data == '0)
        else $error("data not zero on failed operation");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
